// ----- rtl/ai64p_pkg.sv -----
// shared constants and types for the ascii to int64 parser
package ai64p_pkg;

    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 64;
    localparam int COUNT_W    = 16;
    localparam int BASE_W     = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // position counter saturates here
    localparam logic [COUNT_W-1:0] MAX_LEN = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 4'd1;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

    // parse state handed to the result stage
    typedef struct packed {
        logic [VALUE_W-1:0] accumulator;
        logic               is_negative;
        logic               overflowed;
        logic               any_digit;
        logic [COUNT_W-1:0] end_offset;
    } t_parse_result;

endpackage

// ----- rtl/ascii_to_int64_parser_top.sv -----
// top level of the streaming ascii to 64-bit integer parser
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_character
//  result    out        o_out_valid / i_out_ready o_value, o_range_error, o_consumed_count
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one character per cycle while no nul waits in the input register; a character goes input register -> parse state
//  the nul character loads the result register from the input register once the result register has space
//  the radix multiply-accumulate (64 x 6 bits) sets the per-character path
//  a waiting result stalls only a nul in the input register, other characters flow on
//  synchronous reset restores number_base 10 and signed_mode 1, config is always ready
module ascii_to_int64_parser_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ai64p_pkg::CHAR_W-1:0]       i_character,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ai64p_pkg::VALUE_W-1:0]      o_value,
    output logic                               o_range_error,
    output logic [ai64p_pkg::COUNT_W-1:0]      o_consumed_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ai64p_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ai64p_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                            r_in_valid;
    logic [ai64p_pkg::CHAR_W-1:0]    r_char;
    logic [ai64p_pkg::BASE_W-1:0]    r_number_base;
    logic                            r_signed_mode;

    logic                            w_is_nul;
    logic                            w_space;
    logic                            w_advance;
    ai64p_pkg::t_parse_result        w_state;

    assign w_is_nul    = (r_char == '0);
    assign w_advance   = r_in_valid && (!w_is_nul || w_space);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_char <= i_character;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= ai64p_pkg::BASE_RESET;
            r_signed_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ai64p_pkg::REG_NUMBER_BASE: begin
                    r_number_base <= i_cfg_data[ai64p_pkg::BASE_W-1:0];
                end
                ai64p_pkg::REG_SIGNED_MODE: begin
                    r_signed_mode <= i_cfg_data[0];
                end
                default: begin
                    r_signed_mode <= r_signed_mode;
                end
            endcase
        end
    end

    ai64p_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance && !w_is_nul),
        .i_term        (w_advance && w_is_nul),
        .i_char        (r_char),
        .i_number_base (r_number_base),
        .o_state       (w_state)
    );

    ai64p_result u_result (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_advance && w_is_nul),
        .i_signed_mode    (r_signed_mode),
        .i_state          (w_state),
        .i_out_ready      (i_out_ready),
        .o_space          (w_space),
        .o_out_valid      (o_out_valid),
        .o_value          (o_value),
        .o_range_error    (o_range_error),
        .o_consumed_count (o_consumed_count)
    );

endmodule

// ----- rtl/ai64p_parse.sv -----
// per-character parse state machine with the radix multiply-accumulate
module ai64p_parse (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_term,
    input  logic [ai64p_pkg::CHAR_W-1:0]   i_char,
    input  logic [ai64p_pkg::BASE_W-1:0]   i_number_base,
    output ai64p_pkg::t_parse_result       o_state
);

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_SIGNED = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    localparam int PROD_W = ai64p_pkg::VALUE_W + ai64p_pkg::BASE_W;

    t_phase                            r_phase, n_phase;
    logic [ai64p_pkg::VALUE_W-1:0]     r_acc, n_acc;
    logic                              r_neg, n_neg;
    logic                              r_ovf, n_ovf;
    logic                              r_any, n_any;
    logic [ai64p_pkg::BASE_W-1:0]      r_eb, n_eb;
    logic [ai64p_pkg::COUNT_W-1:0]     r_pos, n_pos;
    logic [ai64p_pkg::COUNT_W-1:0]     r_end, n_end;

    logic [ai64p_pkg::BASE_W-1:0]      w_digit;
    logic                              w_is_space;
    logic                              w_is_sign;
    logic                              w_is_x;
    logic                              w_first_zero;
    logic [ai64p_pkg::BASE_W-1:0]      w_first_base;
    logic                              w_first_ok;
    logic                              w_first_phase;
    logic [ai64p_pkg::BASE_W-1:0]      w_take_base;
    logic                              w_digit_ok;
    logic [PROD_W-1:0]                 w_prod;
    logic                              w_take;
    logic                              w_set_zero;

    function automatic logic [ai64p_pkg::BASE_W-1:0] digit_of(
        input logic [ai64p_pkg::CHAR_W-1:0] c
    );
        logic [ai64p_pkg::CHAR_W-1:0] d;
        begin
            if (c >= 8'd48 && c <= 8'd57) begin
                d = c - 8'd48;
            end else if (c >= 8'd97 && c <= 8'd122) begin
                d = c - 8'd87;
            end else if (c >= 8'd65 && c <= 8'd90) begin
                d = c - 8'd55;
            end else begin
                d = 8'd36;
            end
            digit_of = d[ai64p_pkg::BASE_W-1:0];
        end
    endfunction

    assign w_digit    = digit_of(i_char);
    assign w_is_space = (i_char == 8'd32) || (i_char >= 8'd9 && i_char <= 8'd13);
    assign w_is_sign  = (i_char == 8'd43) || (i_char == 8'd45);
    assign w_is_x     = (i_char == 8'd120) || (i_char == 8'd88);

    // radix choice for the first character after whitespace and sign
    assign w_first_zero = (i_char == 8'd48)
                       && (i_number_base == 6'd0 || i_number_base == 6'd16);
    always_comb begin
        if (w_first_zero) begin
            w_first_base = (i_number_base == 6'd0) ? 6'd8 : 6'd16;
        end else if (i_number_base == 6'd0) begin
            w_first_base = 6'd10;
        end else begin
            w_first_base = i_number_base;
        end
    end
    assign w_first_ok = w_first_base >= 6'd2 && w_first_base <= 6'd36;

    assign w_first_phase = (r_phase == PH_SPACE) || (r_phase == PH_SIGNED);
    assign w_take_base   = w_first_phase ? w_first_base : r_eb;
    assign w_digit_ok    = (w_digit < w_take_base) && (w_take_base >= 6'd2);

    // acc * base + digit; anything above bit 63 is an overflow
    assign w_prod = {{ai64p_pkg::BASE_W{1'b0}}, r_acc}
                  * {{ai64p_pkg::VALUE_W{1'b0}}, w_take_base}
                  + {{(PROD_W-ai64p_pkg::BASE_W){1'b0}}, w_digit};

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_ovf      = r_ovf;
        n_any      = r_any;
        n_eb       = r_eb;
        n_pos      = r_pos;
        n_end      = r_end;
        w_take     = 1'b0;
        w_set_zero = 1'b0;
        if (i_term) begin
            n_phase = PH_SPACE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_ovf   = 1'b0;
            n_any   = 1'b0;
            n_eb    = '0;
            n_pos   = '0;
            n_end   = '0;
        end else if (i_step) begin
            if (r_pos < ai64p_pkg::MAX_LEN) begin
                n_pos = r_pos + 16'd1;
            end
            case (r_phase)
                PH_SPACE: begin
                    if (w_is_space) begin
                        n_phase = PH_SPACE;
                    end else if (w_is_sign) begin
                        n_neg   = (i_char == 8'd45);
                        n_phase = PH_SIGNED;
                    end else if (w_first_ok) begin
                        n_eb       = w_first_base;
                        w_take     = 1'b1;
                        w_set_zero = w_first_zero;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SIGNED: begin
                    if (w_first_ok) begin
                        n_eb       = w_first_base;
                        w_take     = 1'b1;
                        w_set_zero = w_first_zero;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_ZERO: begin
                    if (w_is_x) begin
                        n_eb    = 6'd16;
                        n_phase = PH_DIGITS;
                    end else begin
                        w_take = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    w_take = 1'b1;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            if (w_take) begin
                if (w_digit_ok) begin
                    if (w_prod[PROD_W-1:ai64p_pkg::VALUE_W] != '0) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = w_prod[ai64p_pkg::VALUE_W-1:0];
                    end
                    n_any   = 1'b1;
                    n_end   = n_pos;
                    n_phase = w_set_zero ? PH_ZERO : PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_any   <= 1'b0;
            r_eb    <= '0;
            r_pos   <= '0;
            r_end   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
            r_any   <= n_any;
            r_eb    <= n_eb;
            r_pos   <= n_pos;
            r_end   <= n_end;
        end
    end

    assign o_state.accumulator = r_acc;
    assign o_state.is_negative = r_neg;
    assign o_state.overflowed  = r_ovf;
    assign o_state.any_digit   = r_any;
    assign o_state.end_offset  = r_end;

    a_digit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_phase != PH_SPACE && r_phase != PH_SIGNED))
        else $error("digit flag set before any digit phase");

    a_end_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end <= r_pos)
        else $error("end offset beyond position");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_term |=> (r_phase == PH_SPACE && !r_any && !r_ovf && r_pos == '0))
        else $error("parse state not cleared after terminator");

endmodule

// ----- rtl/ai64p_result.sv -----
// saturation, sign handling and the result register
module ai64p_result (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic                            i_signed_mode,
    input  ai64p_pkg::t_parse_result        i_state,
    input  logic                            i_out_ready,
    output logic                            o_space,
    output logic                            o_out_valid,
    output logic [ai64p_pkg::VALUE_W-1:0]   o_value,
    output logic                            o_range_error,
    output logic [ai64p_pkg::COUNT_W-1:0]   o_consumed_count
);

    localparam logic [ai64p_pkg::VALUE_W-1:0] S_MIN = 64'h8000000000000000;
    localparam logic [ai64p_pkg::VALUE_W-1:0] S_MAX = 64'h7FFFFFFFFFFFFFFF;

    logic                            r_out_valid, n_out_valid;
    logic [ai64p_pkg::VALUE_W-1:0]   r_value, n_value;
    logic                            r_err, n_err;
    logic [ai64p_pkg::COUNT_W-1:0]   r_count, n_count;

    logic [ai64p_pkg::VALUE_W-1:0]   w_v;
    logic [ai64p_pkg::VALUE_W-1:0]   w_neg_v;

    assign w_v     = i_state.accumulator;
    assign w_neg_v = ~w_v + 64'd1;

    assign o_space = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_value     = r_value;
        n_err       = r_err;
        n_count     = r_count;
        if (i_load) begin
            n_out_valid = 1'b1;
            n_count     = i_state.any_digit ? i_state.end_offset : '0;
            n_err       = 1'b0;
            n_value     = w_v;
            if (i_signed_mode) begin
                if (i_state.is_negative) begin
                    if (i_state.overflowed || w_v > S_MIN) begin
                        n_value = S_MIN;
                        n_err   = 1'b1;
                    end else begin
                        n_value = w_neg_v;
                    end
                end else if (i_state.overflowed || w_v > S_MAX) begin
                    n_value = S_MAX;
                    n_err   = 1'b1;
                end
            end else if (i_state.overflowed) begin
                n_value = '1;
                n_err   = 1'b1;
            end else if (i_state.is_negative) begin
                n_value = w_neg_v;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_value <= n_value;
        r_err   <= n_err;
        r_count <= n_count;
    end

    assign o_out_valid      = r_out_valid;
    assign o_value          = r_value;
    assign o_range_error    = r_err;
    assign o_consumed_count = r_count;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending transaction");

endmodule
